[hw/rtl/drift_compensating_stereo_rate_bridge_defines.svh]
// Assertion macros used by the rate bridge RTL
`ifndef DRIFT_COMPENSATING_STEREO_RATE_BRIDGE_DEFINES_SVH
`define DRIFT_COMPENSATING_STEREO_RATE_BRIDGE_DEFINES_SVH

// condition that must hold on every clock edge out of reset
`define DCSRB_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define DCSRB_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCSRB_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dcsrb_pkg.sv]
// Shared constants and types of the stereo rate bridge
package dcsrb_pkg;

  // ring and pop block sizing
  localparam int RING_DEPTH = 65536;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MAX_POP    = 64;
  localparam int POP_AW     = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int CNT_W      = $clog2(MAX_POP + 1);

  // field widths
  localparam int RATE_W  = 19;
  localparam int SMP_W   = 24;
  localparam int FRAME_W = 2 * SMP_W;
  localparam int FC_W    = 7;
  localparam int QF_W    = 17;

  // step arithmetic widths
  localparam int TGT_W  = 16;
  localparam int VAL_W  = 20;
  localparam int NUM_W  = 39;
  localparam int DT_W   = 35;
  localparam int DEN_W  = 40;
  localparam int DIVN_W = 72;
  localparam int REM_W  = 41;
  localparam int DCNT_W = 7;

  localparam logic [RATE_W-1:0] RATE_DEFAULT = 19'd48000;
  localparam logic [31:0]       RING_DEPTH32 = 32'(RING_DEPTH);
  localparam logic [TGT_W-1:0]  TGT_FLOOR    = 16'd64;

  // reciprocals for the target fill: exact for a 19-bit rate and for 35 times that rate
  localparam logic [18:0] RECIP_10   = 19'd419431;    // ceil(2^22 / 10)
  localparam logic [24:0] RECIP_1000 = 25'd17179870;  // ceil(2^34 / 1000)

  // action codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic REG_SRC = 1'b0;
  localparam logic REG_DST = 1'b1;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/dcsrb_if.sv]
// Channel interfaces: input words, result words and configuration writes
interface dcsrb_in_if import dcsrb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  smp_t            left_in;
  smp_t            right_in;
  logic            mono;
  logic            block_end;
  logic [FC_W-1:0] frame_count;
  modport source (output valid, action, left_in, right_in, mono, block_end, frame_count,
                  input ready);
  modport sink   (input valid, action, left_in, right_in, mono, block_end, frame_count,
                  output ready);
endinterface

interface dcsrb_out_if import dcsrb_pkg::*; ();
  logic            valid;
  logic            ready;
  smp_t            left_out;
  smp_t            right_out;
  logic            last;
  logic [QF_W-1:0] queued_frames;
  logic [31:0]     underrun_total;
  logic [31:0]     overrun_total;
  modport source (output valid, left_out, right_out, last, queued_frames, underrun_total,
                  overrun_total, input ready);
  modport sink   (input valid, left_out, right_out, last, queued_frames, underrun_total,
                  overrun_total, output ready);
endinterface

interface dcsrb_cfg_if import dcsrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              index;
  logic [RATE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/drift_compensating_stereo_rate_bridge.sv]
// A push or clear word is taken while the sequencer is idle; an unprimed pop goes from S_PRM to S_ERD.
// A primed pop computes the target and the numerator, runs a 72-bit step divide, then interpolates each frame.
// Each frame takes two ring RAM reads, a multiply and an interpolate; S_FIN then ends the block.
// Results leave one at a time from the staging buffer, held while the sink holds off ready.
// Reset (rst_n, synchronous): counters, position, flags cleared, rates back to 48000.
// Ring contents are not cleared; they stay undefined until written.
module drift_compensating_stereo_rate_bridge import dcsrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dcsrb_in_if.sink    in_ch,
  dcsrb_out_if.source out_ch,
  dcsrb_cfg_if.sink   cfg_ch
);

`include "drift_compensating_stereo_rate_bridge_defines.svh"

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TGT  = 4'd1;
  localparam logic [3:0] S_PRM  = 4'd2;
  localparam logic [3:0] S_NUM  = 4'd3;
  localparam logic [3:0] S_DEN  = 4'd4;
  localparam logic [3:0] S_STP  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_RDA  = 4'd7;
  localparam logic [3:0] S_RDB  = 4'd8;
  localparam logic [3:0] S_LRP  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_EOUT = 4'd12;

  logic [3:0]        state_r;
  logic [RATE_W-1:0] src_r, dst_r;
  logic [31:0]       wc_r, rw_r, rf_r, und_r, ovr_r;
  logic              primed_r, bdrop_r;
  logic [CNT_W-1:0]  n_r, produced_r, k_r;
  logic [31:0]       fill_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [VAL_W-1:0]  val_r;
  logic [DT_W-1:0]   dt_r;
  logic [NUM_W-1:0]  num_r;
  logic [63:0]       step_r;
  smp_t              a_l_r, a_r_r;
  logic signed [57:0] prod_l_r, prod_r_r;

  // output register
  logic              ov_r;
  smp_t              ol_r, or_r;
  logic              olast_r;
  logic [QF_W-1:0]   oq_r;
  logic [31:0]       ou_r, oo_r;

  // ----- effective rates and target fill by reciprocal multiply
  logic [RATE_W-1:0] src_eff, dst_eff;
  logic              rates_eq;
  logic [25:0]       src35;
  logic [37:0]       q10_p;
  logic [50:0]       q1000_p;
  logic [TGT_W-1:0]  tgt_raw;
  logic [31:0]       cur_fill;
  logic              in_acc, is_push, is_pop, is_clear, push_fits;
  logic [CNT_W-1:0]  n_clamp;
  smp_t              push_r_smp;

  always_comb begin
    src_eff    = (src_r == '0) ? RATE_DEFAULT : src_r;
    dst_eff    = (dst_r == '0) ? RATE_DEFAULT : dst_r;
    rates_eq   = src_eff == dst_eff;
    src35      = 26'(src_eff) * 26'd35;
    q10_p      = 38'(src_eff) * 38'(RECIP_10);
    q1000_p    = 51'(src35) * 51'(RECIP_1000);
    tgt_raw    = rates_eq ? q1000_p[34 +: TGT_W] : q10_p[22 +: TGT_W];
    cur_fill   = wc_r - rw_r;
    in_acc     = in_ch.valid && in_ch.ready;
    is_push    = in_acc && (in_ch.action == ACT_PUSH);
    is_pop     = in_acc && (in_ch.action == ACT_POP) && (in_ch.frame_count != '0);
    is_clear   = in_acc && (in_ch.action == ACT_CLEAR);
    push_fits  = cur_fill < RING_DEPTH32;
    n_clamp    = (in_ch.frame_count > FC_W'(MAX_POP)) ? CNT_W'(MAX_POP)
                                                      : CNT_W'(in_ch.frame_count);
    push_r_smp = in_ch.mono ? in_ch.left_in : in_ch.right_in;
  end

  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;

  // ----- step divider
  logic              div_start;
  logic [DIVN_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0]  div_den;
  div_stat_t         dstat;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == S_DEN) begin
      div_start = 1'b1;
      div_num   = DIVN_W'({num_r, 32'h0});
      div_den   = DEN_W'({dt_r, 4'b0}) + DEN_W'({dt_r, 2'b0});
    end
  end

  dcsrb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (dstat)
  );

  // ----- ring memory, both channels side by side
  logic                ring_re;
  logic [RING_AW-1:0]  ring_raddr;
  logic [FRAME_W-1:0]  ring_rdata;
  smp_t                rd_l, rd_r;

  always_comb begin
    ring_re    = (state_r == S_CHK) || (state_r == S_RDA);
    ring_raddr = (state_r == S_RDA) ? RING_AW'(rw_r[RING_AW-1:0] + 1'b1)
                                    : rw_r[RING_AW-1:0];
    rd_l       = ring_rdata[SMP_W-1:0];
    rd_r       = ring_rdata[FRAME_W-1:SMP_W];
  end

  dcsrb_ram #(.WIDTH(FRAME_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (is_push && push_fits),
    .waddr (wc_r[RING_AW-1:0]),
    .wdata ({push_r_smp, in_ch.left_in}),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // ----- step numerator term: 19T + min(fill, 2T)
  logic [TGT_W:0]     tgt2;
  logic [TGT_W:0]     fmin;
  logic [VAL_W-1:0]   val_nxt;
  logic               prime_now;

  always_comb begin
    tgt2      = {tgt_r, 1'b0};
    fmin      = (fill_r > 32'(tgt2)) ? tgt2 : fill_r[TGT_W:0];
    val_nxt   = VAL_W'(tgt_r) * VAL_W'(19) + VAL_W'(fmin);
    prime_now = primed_r || (fill_r >= 32'(tgt_r));
  end

  // ----- interpolation
  logic signed [24:0] dif_l, dif_r;
  logic signed [32:0] frs;
  logic signed [57:0] prod_l_nxt, prod_r_nxt;
  logic signed [57:0] rnd_l, rnd_r;
  smp_t               res_l, res_r;
  logic [31:0]        d_frame;
  logic               frame_ok;

  always_comb begin
    dif_l      = {rd_l[SMP_W-1], rd_l} - {a_l_r[SMP_W-1], a_l_r};
    dif_r      = {rd_r[SMP_W-1], rd_r} - {a_r_r[SMP_W-1], a_r_r};
    frs        = {1'b0, rf_r};
    prod_l_nxt = dif_l * frs;
    prod_r_nxt = dif_r * frs;
    rnd_l      = prod_l_r + 58'sd2147483648;
    rnd_r      = prod_r_r + 58'sd2147483648;
    res_l      = a_l_r + smp_t'(rnd_l[32 +: SMP_W]);
    res_r      = a_r_r + smp_t'(rnd_r[32 +: SMP_W]);
    d_frame    = wc_r - rw_r;
    frame_ok   = (d_frame >= 32'd2) && (d_frame <= RING_DEPTH32);
  end

  // ----- staging buffer for one pop block
  logic [FRAME_W-1:0] rbuf_rdata;

  dcsrb_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_POP)) u_stage (
    .clk   (clk),
    .we    (state_r == S_LRP),
    .waddr (produced_r[POP_AW-1:0]),
    .wdata ({res_r, res_l}),
    .re    (state_r == S_ERD),
    .raddr (k_r[POP_AW-1:0]),
    .rdata (rbuf_rdata)
  );

  // ----- output load
  logic out_load, last_nxt;
  assign out_load = (state_r == S_EOUT) && (!ov_r || out_ch.ready);
  assign last_nxt = (k_r + 1'b1) == n_r;

  // ----- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= RATE_DEFAULT;
      dst_r <= RATE_DEFAULT;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_SRC) begin
        src_r <= cfg_ch.data;
      end else begin
        dst_r <= cfg_ch.data;
      end
    end
  end

  // ----- sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wc_r       <= '0;
      rw_r       <= '0;
      rf_r       <= '0;
      und_r      <= '0;
      ovr_r      <= '0;
      primed_r   <= 1'b0;
      bdrop_r    <= 1'b0;
      n_r        <= '0;
      produced_r <= '0;
      k_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (is_push) begin
            if (push_fits) begin
              wc_r <= wc_r + 1'b1;
            end else if (!bdrop_r) begin
              ovr_r <= ovr_r + 1'b1;
            end
            // block_end closes the push block
            bdrop_r <= !in_ch.block_end && (bdrop_r || !push_fits);
          end else if (is_clear) begin
            wc_r     <= '0;
            rw_r     <= '0;
            rf_r     <= '0;
            und_r    <= '0;
            ovr_r    <= '0;
            primed_r <= 1'b0;
            bdrop_r  <= 1'b0;
          end else if (is_pop) begin
            n_r        <= n_clamp;
            produced_r <= '0;
            state_r    <= S_TGT;
          end
        end
        S_TGT: state_r <= S_PRM;
        S_PRM: begin
          if (!primed_r && (fill_r >= 32'(tgt_r))) begin
            primed_r <= 1'b1;
            rf_r     <= '0;
          end
          k_r     <= '0;
          state_r <= prime_now ? S_NUM : S_ERD;
        end
        S_NUM: state_r <= S_DEN;
        S_DEN: state_r <= S_STP;
        S_STP: begin
          if (dstat.done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: state_r <= frame_ok ? S_RDA : S_FIN;
        S_RDA: state_r <= S_RDB;
        S_RDB: state_r <= S_LRP;
        S_LRP: begin
          {rw_r, rf_r} <= {rw_r, rf_r} + step_r;
          produced_r   <= produced_r + 1'b1;
          state_r      <= ((produced_r + 1'b1) == n_r) ? S_FIN : S_CHK;
        end
        S_FIN: begin
          // pull the position back if it ran ahead of the writer
          if (d_frame > RING_DEPTH32) begin
            rw_r <= wc_r;
            rf_r <= '0;
          end
          if (produced_r < n_r) begin
            und_r    <= und_r + 1'b1;
            primed_r <= 1'b0;
          end
          k_r     <= '0;
          state_r <= S_ERD;
        end
        S_ERD: state_r <= S_EOUT;
        S_EOUT: begin
          if (out_load) begin
            k_r     <= k_r + 1'b1;
            state_r <= last_nxt ? S_IDLE : S_ERD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ----- arithmetic registers
  always_ff @(posedge clk) begin
    if (is_pop) begin
      fill_r <= cur_fill;
    end
    if (state_r == S_TGT) begin
      tgt_r <= (tgt_raw < TGT_FLOOR) ? TGT_FLOOR : tgt_raw;
    end
    if (state_r == S_PRM) begin
      val_r <= val_nxt;
      dt_r  <= DT_W'(dst_eff) * DT_W'(tgt_r);
    end
    if (state_r == S_NUM) begin
      num_r <= NUM_W'(src_eff) * NUM_W'(val_r);
    end
    if (state_r == S_STP && dstat.done) begin
      step_r <= div_quo[63:0];
    end
    if (state_r == S_RDA) begin
      a_l_r <= rd_l;
      a_r_r <= rd_r;
    end
    if (state_r == S_RDB) begin
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
    end
  end

  // ----- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (k_r < produced_r) begin
        ol_r <= rbuf_rdata[SMP_W-1:0];
        or_r <= rbuf_rdata[FRAME_W-1:SMP_W];
      end else begin
        ol_r <= '0;
        or_r <= '0;
      end
      olast_r <= last_nxt;
      oq_r    <= d_frame[QF_W-1:0];
      ou_r    <= und_r;
      oo_r    <= ovr_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.left_out       = ol_r;
  assign out_ch.right_out      = or_r;
  assign out_ch.last           = olast_r;
  assign out_ch.queued_frames  = oq_r;
  assign out_ch.underrun_total = ou_r;
  assign out_ch.overrun_total  = oo_r;

  // ----- checks (position may run past the writer until the block ends)
  `DCSRB_IMPLIES(a_fill_bound, state_r != S_CHK && state_r != S_FIN, (wc_r - rw_r) <= RING_DEPTH32, "ring fill beyond depth")
  `DCSRB_IMPLIES(a_loop_count, state_r == S_CHK, produced_r < n_r, "frame loop overran block")
  `DCSRB_IMPLIES(a_emit_count, state_r == S_ERD || state_r == S_EOUT, k_r < n_r && produced_r <= n_r, "emit index out of block")
  `DCSRB_NEXT(a_prime_frac, state_r == S_PRM && !primed_r && fill_r >= 32'(tgt_r), primed_r && rf_r == '0, "priming did not zero fraction")

endmodule

[hw/rtl/dcsrb_ram.sv]
// Generic single-write, single-read RAM with registered read data
module dcsrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/dcsrb_div.sv]
// Restoring divider, one quotient bit per cycle
module dcsrb_div import dcsrb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [DIVN_W-1:0] quo,
  output div_stat_t         stat
);

  logic [DIVN_W-1:0] q_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_sh;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], q_r[DIVN_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVN_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
